### hdl/sls_pkg.sv
// Shared types and constants for the status LED sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package sls_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned NMODE_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COLOR_W-1:0] FULL_SCALE = 16'hFFFF;

  localparam logic [CFG_W-1:0] BLINK_INTERVAL_RST = 16'd50;
  localparam logic [CFG_W-1:0] SUCCESS_HOLD_RST   = 16'd300;
  localparam logic [CFG_W-1:0] ERROR_HOLD_RST     = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_HOLD     = 2'd2;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [NMODE_W-1:0] NM_IDLE    = 3'd0;
  localparam logic [NMODE_W-1:0] NM_ACTIVE  = 3'd1;
  localparam logic [NMODE_W-1:0] NM_SUCCESS = 3'd2;
  localparam logic [NMODE_W-1:0] NM_ERROR   = 3'd3;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_ACTIVE  = 4'b0010,
    MODE_SUCCESS = 4'b0100,
    MODE_ERROR   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic               req_type;
    logic [NMODE_W-1:0] new_mode;
    logic [TIME_W-1:0]  now_ms;
    logic               driver_ready;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CFG_W-1:0] blink_interval_ms;
    logic [CFG_W-1:0] success_hold_ms;
    logic [CFG_W-1:0] error_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic push;
  } core_ctl_t;

  function automatic mode_t decode_mode(input logic [NMODE_W-1:0] code);
    mode_t m;
    case (code)
      NM_ACTIVE:  m = MODE_ACTIVE;
      NM_SUCCESS: m = MODE_SUCCESS;
      NM_ERROR:   m = MODE_ERROR;
      default:    m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### hdl/sls_in_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on sls_pkg.
`default_nettype none

interface sls_in_if;
  import sls_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [NMODE_W-1:0] new_mode;
  logic [TIME_W-1:0]  now_ms;
  logic               driver_ready;

  modport source (output valid, req_type, new_mode, now_ms, driver_ready, input ready);
  modport sink   (input valid, req_type, new_mode, now_ms, driver_ready, output ready);
endinterface

`default_nettype wire

### hdl/sls_out_if.sv
// Pixel channel: valid/ready handshake carrying one RGB word.
// Depends on sls_pkg.
`default_nettype none

interface sls_out_if;
  import sls_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

### hdl/status_led_sequencer.sv
// Top level of the status LED sequencer: input register, mode core, pixel register.
// Depends on sls_pkg, sls_in_if, sls_out_if, sls_cfg_regs, sls_core, sls_out_buf.
//
//   port      role     word contents
//   req       sink     req_type, new_mode, now_ms, driver_ready
//   pix       source   red, green, blue
//   cfg_*     write    cfg_index selects register, cfg_data is the value
//
// One request word is taken per cycle unless the core stalls; a taken word
// sits in the request register and its pixel goes to pix via the pixel register.
// The throughput is set by the single mode/timer update stage between the
// request register and the pixel register. Reset is synchronous; req.ready is
// high right after it. A held pixel stalls only a request that produces another pixel.
`default_nettype none

module status_led_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  sls_in_if.sink                             req,
  sls_out_if.source                          pix,
  input  wire logic                          cfg_we,
  input  wire logic [sls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sls_pkg::CFG_W-1:0]     cfg_data
);
  import sls_pkg::*;

  cfg_t      cfg;
  logic      in_v;
  in_word_t  in_word;
  core_ctl_t ctl;
  pixel_t    pixel;
  logic      slot_free;

  sls_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign req.ready = !in_v || ctl.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (req.ready) begin
      in_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_word.req_type     <= req.req_type;
      in_word.new_mode     <= req.new_mode;
      in_word.now_ms       <= req.now_ms;
      in_word.driver_ready <= req.driver_ready;
    end
  end

  sls_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_v),
    .item       (in_word),
    .slot_free  (slot_free),
    .ctl        (ctl),
    .pixel      (pixel)
  );

  sls_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (ctl.push),
    .pixel     (pixel),
    .slot_free (slot_free),
    .pix       (pix)
  );

  a_push_needs_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> (!pix.valid || pix.ready))
    else $error("pixel pushed into an occupied result register");

  a_advance_needs_word: assert property (@(posedge clk) disable iff (rst)
    ctl.advance |-> in_v)
    else $error("core advanced without a held request");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> req.ready)
    else $error("request channel not ready after reset");

  a_single_color: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> ($countones({pixel.red != '0, pixel.green != '0, pixel.blue != '0}) <= 1))
    else $error("pixel drives more than one color");

endmodule

`default_nettype wire

### hdl/sls_cfg_regs.sv
// Configuration registers: blink interval and the two hold times.
// Depends on sls_pkg.
`default_nettype none

module sls_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [sls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sls_pkg::CFG_W-1:0]  cfg_data,
  output sls_pkg::cfg_t                   cfg
);
  import sls_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.blink_interval_ms <= BLINK_INTERVAL_RST;
      regs.success_hold_ms   <= SUCCESS_HOLD_RST;
      regs.error_hold_ms     <= ERROR_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLINK_INTERVAL: regs.blink_interval_ms <= cfg_data;
        CFG_SUCCESS_HOLD:   regs.success_hold_ms   <= cfg_data;
        CFG_ERROR_HOLD:     regs.error_hold_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

### hdl/sls_core.sv
// Mode state and per-word update: set-mode handling, hold expiry, blink timing
// and pixel selection. Depends on sls_pkg.
`default_nettype none

module sls_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sls_pkg::cfg_t    cfg,
  input  wire logic             item_valid,
  input  wire sls_pkg::in_word_t item,
  input  wire logic             slot_free,
  output sls_pkg::core_ctl_t    ctl,
  output sls_pkg::pixel_t       pixel
);
  import sls_pkg::*;

  mode_t             mode, mode_next;
  logic              display_current, display_current_next;
  logic              blink_on, blink_on_next;
  logic [TIME_W-1:0] hold_deadline, hold_deadline_next;
  logic [TIME_W-1:0] next_frame_time, next_frame_time_next;

  mode_t             req_mode;
  logic [CFG_W-1:0]  hold_sel;
  logic [TIME_W-1:0] hold_sum;
  logic [TIME_W-1:0] frame_sum;
  logic [TIME_W-1:0] dl_diff;
  logic [TIME_W-1:0] nft_diff;
  logic              expire;
  logic              due;
  logic              want_push;
  logic              advance;

  assign req_mode  = decode_mode(item.new_mode);
  assign hold_sel  = (item.new_mode == NM_SUCCESS) ? cfg.success_hold_ms : cfg.error_hold_ms;
  assign hold_sum  = item.now_ms + {{(TIME_W-CFG_W){1'b0}}, hold_sel};
  assign frame_sum = item.now_ms + {{(TIME_W-CFG_W){1'b0}}, cfg.blink_interval_ms};
  assign dl_diff   = item.now_ms - hold_deadline;
  assign nft_diff  = item.now_ms - next_frame_time;
  assign expire    = (mode != MODE_ACTIVE) && (hold_deadline != '0) && !dl_diff[TIME_W-1];

  always_comb begin
    mode_next            = mode;
    display_current_next = display_current;
    blink_on_next        = blink_on;
    hold_deadline_next   = hold_deadline;
    next_frame_time_next = next_frame_time;
    due                  = 1'b0;
    want_push            = 1'b0;
    pixel                = '0;

    if (item.req_type == REQ_SET) begin
      if (item.new_mode <= NM_ERROR) begin
        if (req_mode == mode) begin
          if (mode == MODE_SUCCESS || mode == MODE_ERROR) begin
            hold_deadline_next = hold_sum;
          end
        end else begin
          mode_next            = req_mode;
          display_current_next = 1'b0;
          next_frame_time_next = '0;
          case (req_mode)
            MODE_ACTIVE: begin
              blink_on_next      = 1'b1;
              hold_deadline_next = '0;
            end
            MODE_SUCCESS, MODE_ERROR: hold_deadline_next = hold_sum;
            default:                  hold_deadline_next = '0;
          endcase
        end
      end
    end else begin
      if (expire) begin
        mode_next            = MODE_IDLE;
        hold_deadline_next   = '0;
        display_current_next = 1'b0;
        next_frame_time_next = '0;
      end

      if (mode_next == MODE_ACTIVE) begin
        due        = !nft_diff[TIME_W-1];
        pixel.blue = blink_on ? FULL_SCALE : '0;
      end else begin
        due         = !display_current_next;
        pixel.red   = (mode_next == MODE_ERROR)   ? FULL_SCALE : '0;
        pixel.green = (mode_next == MODE_SUCCESS) ? FULL_SCALE : '0;
        pixel.blue  = (mode_next == MODE_IDLE)    ? FULL_SCALE : '0;
      end

      want_push = due && item.driver_ready;
      if (want_push) begin
        display_current_next = 1'b1;
        if (mode_next == MODE_ACTIVE) begin
          blink_on_next        = !blink_on;
          next_frame_time_next = frame_sum;
        end
      end
    end
  end

  assign advance     = item_valid && (!want_push || slot_free);
  assign ctl.advance = advance;
  assign ctl.push    = advance && want_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      display_current <= 1'b0;
      blink_on        <= 1'b1;
      hold_deadline   <= '0;
      next_frame_time <= '0;
    end else if (advance) begin
      mode            <= mode_next;
      display_current <= display_current_next;
      blink_on        <= blink_on_next;
      hold_deadline   <= hold_deadline_next;
      next_frame_time <= next_frame_time_next;
    end
  end

endmodule

`default_nettype wire

### hdl/sls_out_buf.sv
// Result register for the pixel channel; drains while the next word is worked.
// Depends on sls_pkg and sls_out_if.
`default_nettype none

module sls_out_buf (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire sls_pkg::pixel_t pixel,
  output logic              slot_free,
  sls_out_if.source         pix
);
  import sls_pkg::*;

  logic   valid;
  pixel_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (pix.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= pixel;
    end
  end

  assign slot_free = !valid || pix.ready;
  assign pix.valid = valid;
  assign pix.red   = held.red;
  assign pix.green = held.green;
  assign pix.blue  = held.blue;

endmodule

`default_nettype wire

### sim/status_led_sequencer_tb.sv
// Self-checking testbench for status_led_sequencer: scripted and random request words,
// pixels checked against a pinned script pixel or an in-bench mode/blink/hold model.
// Depends on sls_pkg, sls_in_if, sls_out_if and the RTL under hdl.
`timescale 1ns / 1ps

module status_led_sequencer_tb;
  import sls_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 20;
  localparam int PHASES       = 7;
  localparam int PHASE_WORDS  = 245;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  localparam pixel_t PX_DARK  = '{red: 16'h0, green: 16'h0, blue: 16'h0};
  localparam pixel_t PX_BLUE  = '{red: 16'h0, green: 16'h0, blue: FULL_SCALE};

  typedef struct packed {
    in_word_t word;
    logic     pinned;
    logic     has_pixel;
    pixel_t   pixel;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{REQ_TICK, NM_IDLE,    32'h0000_0000, 1'b1}, 1'b1, 1'b1, PX_BLUE},
    '{'{REQ_TICK, NM_ACTIVE,  32'hFFFF_FFFF, 1'b1}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_SET,  3'd7,       32'h0000_0000, 1'b1}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_SET,  3'd4,       32'h0000_0000, 1'b0}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_SET,  NM_IDLE,    32'h0000_0005, 1'b0}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_SET,  NM_ERROR,   32'hFFFF_FE0C, 1'b1}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h7FFF_FFFF, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_SET,  NM_SUCCESS, 32'h0000_0064, 1'b0}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_018F, 1'b0}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_018F, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_SET,  NM_SUCCESS, 32'h0000_00C8, 1'b0}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_01C2, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_01F4, 1'b0}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_01F5, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_SET,  NM_ACTIVE,  32'h8000_0000, 1'b1}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h8000_0000, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'hFFFF_FFFF, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_0000, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_0031, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_0032, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_SET,  NM_ACTIVE,  32'h0000_003C, 1'b0}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_0064, 1'b0}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_SET,  NM_ERROR,   32'h0000_00C8, 1'b1}, 1'b1, 1'b0, PX_DARK},
    '{'{REQ_TICK, NM_IDLE,    32'h0000_02BC, 1'b1}, 1'b0, 1'b0, PX_DARK},
    '{'{REQ_SET,  NM_IDLE,    32'h0000_0320, 1'b1}, 1'b1, 1'b0, PX_DARK}
  };

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sls_in_if  req_ch ();
  sls_out_if pix_ch ();

  status_led_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .pix       (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  logic [CFG_W-1:0]  blink_ms   = BLINK_INTERVAL_RST;
  logic [CFG_W-1:0]  success_ms = SUCCESS_HOLD_RST;
  logic [CFG_W-1:0]  error_ms   = ERROR_HOLD_RST;
  mode_t             led_mode   = MODE_IDLE;
  bit                shown      = 1'b0;
  bit                blink_lit  = 1'b1;
  logic [TIME_W-1:0] hold_until = '0;
  logic [TIME_W-1:0] next_frame = '0;

  pixel_t            pending_pixels [$];
  int                error_count = 0;
  int                cycle_count = 0;
  bit                calm = 1'b0;
  logic [TIME_W-1:0] sim_now;
  int unsigned       time_step_max;

  task automatic note_error(input string what);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic bit at_or_past(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] mark);
    logic [TIME_W-1:0] d;
    d = now - mark;
    return ~d[TIME_W-1];
  endfunction

  function automatic bit predict_pixel(input in_word_t w, output pixel_t px);
    mode_t want_mode;
    px = PX_DARK;
    if (w.req_type == REQ_SET) begin
      if (w.new_mode > NM_ERROR)
        return 1'b0;
      case (w.new_mode)
        NM_ACTIVE:  want_mode = MODE_ACTIVE;
        NM_SUCCESS: want_mode = MODE_SUCCESS;
        NM_ERROR:   want_mode = MODE_ERROR;
        default:    want_mode = MODE_IDLE;
      endcase
      if (want_mode == led_mode && (want_mode == MODE_IDLE || want_mode == MODE_ACTIVE))
        return 1'b0;
      if (want_mode != led_mode) begin
        led_mode   = want_mode;
        shown      = 1'b0;
        next_frame = '0;
        if (want_mode == MODE_ACTIVE)
          blink_lit = 1'b1;
      end
      case (want_mode)
        MODE_SUCCESS: hold_until = w.now_ms + 32'(success_ms);
        MODE_ERROR:   hold_until = w.now_ms + 32'(error_ms);
        default:      hold_until = '0;
      endcase
      return 1'b0;
    end

    if (led_mode != MODE_ACTIVE && hold_until != '0 && at_or_past(w.now_ms, hold_until)) begin
      led_mode   = MODE_IDLE;
      hold_until = '0;
      shown      = 1'b0;
      next_frame = '0;
    end

    if (led_mode == MODE_ACTIVE) begin
      if (!at_or_past(w.now_ms, next_frame))
        return 1'b0;
      px.blue = blink_lit ? FULL_SCALE : '0;
    end else begin
      if (shown)
        return 1'b0;
      px.red   = (led_mode == MODE_ERROR)   ? FULL_SCALE : '0;
      px.green = (led_mode == MODE_SUCCESS) ? FULL_SCALE : '0;
      px.blue  = (led_mode == MODE_IDLE)    ? FULL_SCALE : '0;
    end

    if (!w.driver_ready)
      return 1'b0;
    shown = 1'b1;
    if (led_mode == MODE_ACTIVE) begin
      blink_lit  = !blink_lit;
      next_frame = w.now_ms + 32'(blink_ms);
    end
    return 1'b1;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int unsigned pick;
    logic [CFG_W-1:0] hold;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0)
      sim_now = $urandom;
    else
      sim_now = sim_now + $urandom_range(0, time_step_max);
    w.now_ms       = sim_now;
    w.new_mode     = 3'($urandom_range(0, 7));
    w.driver_ready = ($urandom_range(0, 4) != 0);
    if (pick < 8) begin
      w.req_type = REQ_SET;
      w.new_mode = 3'($urandom_range(4, 7));
    end else if (pick < 40) begin
      w.req_type = REQ_SET;
      w.new_mode = 3'($urandom_range(0, 3));
      // land the deadline exactly on zero
      if ($urandom_range(0, 11) == 0) begin
        hold     = (w.new_mode == NM_SUCCESS) ? success_ms : error_ms;
        w.now_ms = 32'd0 - 32'(hold);
        sim_now  = w.now_ms;
      end
    end else begin
      w.req_type = REQ_TICK;
    end
    return w;
  endfunction

  task automatic put_word(input in_word_t w);
    req_ch.req_type     <= w.req_type;
    req_ch.new_mode     <= w.new_mode;
    req_ch.now_ms       <= w.now_ms;
    req_ch.driver_ready <= w.driver_ready;
  endtask

  task automatic send_word(input in_word_t w, input bit pinned, input bit has_pixel,
                           input pixel_t pixel);
    pixel_t px;
    bit     has;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      put_word(in_word_t'({$urandom, $urandom}));
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    put_word(w);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    has = predict_pixel(w, px);
    if (pinned) begin
      has = has_pixel;
      px  = pixel;
    end
    if (has)
      pending_pixels.push_back(px);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_BLINK_INTERVAL: blink_ms   = data;
      CFG_SUCCESS_HOLD:   success_ms = data;
      CFG_ERROR_HOLD:     error_ms   = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t    w;
    int          counted;
    logic [15:0] iv, sh, eh;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_SET;
    req_ch.new_mode     <= NM_IDLE;
    req_ch.now_ms       <= '0;
    req_ch.driver_ready <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_word(SCRIPT[i].word, SCRIPT[i].pinned, SCRIPT[i].has_pixel, SCRIPT[i].pixel);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
      case (ph)
        0: begin iv = 16'd0;     sh = 16'd0;     eh = 16'd0;     end
        1: begin iv = 16'hFFFF;  sh = 16'hFFFF;  eh = 16'hFFFF;  end
        2: begin iv = 16'd1;     sh = 16'd1;     eh = 16'd1;     end
        3: begin
          iv = 16'($urandom_range(1, 200));
          sh = 16'($urandom_range(1, 200));
          eh = 16'($urandom_range(1, 200));
        end
        4: begin iv = BLINK_INTERVAL_RST; sh = SUCCESS_HOLD_RST; eh = ERROR_HOLD_RST; end
        5: begin
          iv = 16'($urandom_range(1, 65535));
          sh = 16'($urandom_range(1, 65535));
          eh = 16'($urandom_range(1, 65535));
        end
        default: begin
          iv = 16'($urandom_range(1, 40));
          sh = 16'($urandom_range(1, 40));
          eh = 16'($urandom_range(1, 40));
        end
      endcase
      write_reg(CFG_BLINK_INTERVAL, iv);
      write_reg(CFG_SUCCESS_HOLD, sh);
      write_reg(CFG_ERROR_HOLD, eh);
      write_reg(CFG_NONE, 16'($urandom));
      cfg_we <= 1'b0;

      case (ph)
        1:       sim_now = 32'hFFFF_0000;
        4:       sim_now = 32'h7FFF_FF00;
        default: sim_now = $urandom;
      endcase
      time_step_max = iv;
      if (sh > time_step_max) time_step_max = sh;
      if (eh > time_step_max) time_step_max = eh;
      time_step_max = time_step_max / 4 + 2;

      counted = 0;
      while (counted < PHASE_WORDS) begin
        if (ph == PHASES - 1)
          calm = 1'b1;
        else if ($urandom_range(0, 63) == 0)
          calm = !calm;
        w = random_word();
        send_word(w, 1'b0, 1'b0, PX_DARK);
        counted++;
        // hold the sender until every pixel is out
        if (ph == 3 && counted == 120)
          wait_drained();
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0)
      note_error($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    pix_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 6) == 0) begin
        pix_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      pix_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("unexpected pixel %h/%h/%h",
                             pix_ch.red, pix_ch.green, pix_ch.blue));
      end else begin
        want = pending_pixels.pop_front();
        if (pix_ch.red !== want.red || pix_ch.green !== want.green ||
            pix_ch.blue !== want.blue)
          note_error($sformatf("pixel mismatch: expected %h/%h/%h got %h/%h/%h",
                               want.red, want.green, want.blue,
                               pix_ch.red, pix_ch.green, pix_ch.blue));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

### files.f
hdl/sls_pkg.sv
hdl/sls_in_if.sv
hdl/sls_out_if.sv
hdl/sls_cfg_regs.sv
hdl/sls_core.sv
hdl/sls_out_buf.sv
hdl/status_led_sequencer.sv
sim/status_led_sequencer_tb.sv
